>>> hw/rtl/bhpq_pkg.sv
package bhpq_pkg;

  // Sizes follow the fixed widths of the transaction fields
  localparam int CAPACITY = 1023;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 10;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADSLOT = 2'd3;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ROOT_IDX = CNT_W'(1);

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [CNT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [KEY_W-1:0] popped;
    logic [KEY_W-1:0] top;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
  } res_t;

  // True when key a has strictly higher priority than key b
  function automatic logic beats(input logic mode, input logic [KEY_W-1:0] a,
                                 input logic [KEY_W-1:0] b);
    beats = mode ? (a > b) : (a < b);
  endfunction

endpackage

>>> hw/rtl/bhpq_ram.sv
module bhpq_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 2 ** AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bhpq_seq.sv
module bhpq_seq
  import bhpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             order_mode,
  input  logic             start,
  input  logic [OP_W-1:0]  operation,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] slot,
  input  logic [KEY_W-1:0] rd_data,
  output mem_req_t         mem,
  output res_t             res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_POP_LAT = 3'd1;
  localparam logic [2:0] S_UP_CHK  = 3'd2;
  localparam logic [2:0] S_UP_CMP  = 3'd3;
  localparam logic [2:0] S_DN_CHK  = 3'd4;
  localparam logic [2:0] S_DN_L    = 3'd5;
  localparam logic [2:0] S_DN_R    = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [KEY_W-1:0] cur, cur_next;
  logic [KEY_W-1:0] lkey, lkey_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [KEY_W-1:0] root;
  logic [KEY_W-1:0] popped, popped_next;
  logic [ST_W-1:0]  status, status_next;
  logic             upd, upd_next;

  logic [CNT_W:0]   child, child_r, cnt_x;
  logic [KEY_W-1:0] best_key;
  logic [CNT_W-1:0] best_idx;

  assign child   = {pos, 1'b0};
  assign child_r = child + (CNT_W+1)'(1);
  assign cnt_x   = {1'b0, cnt};

  // Right child wins ties
  always_comb begin
    if (!beats(order_mode, lkey, rd_data)) begin
      best_key = rd_data;
      best_idx = child_r[CNT_W-1:0];
    end else begin
      best_key = lkey;
      best_idx = child[CNT_W-1:0];
    end
  end

  // The moving key stays in cur and is written once, where the sift stops
  always_comb begin
    state_next  = state;
    pos_next    = pos;
    cur_next    = cur;
    lkey_next   = lkey;
    cnt_next    = cnt;
    popped_next = popped;
    status_next = status;
    upd_next    = upd;
    mem.we      = 1'b0;
    mem.waddr   = pos;
    mem.wdata   = cur;
    mem.raddr   = pos;
    case (state)
      S_IDLE: begin
        if (start) begin
          popped_next = '0;
          status_next = ST_OK;
          case (operation)
            OP_PUSH: begin
              if (cnt == CAP_CNT) begin
                status_next = ST_FULL;
                state_next  = S_DONE;
              end else begin
                cnt_next   = cnt + CNT_W'(1);
                pos_next   = cnt + CNT_W'(1);
                cur_next   = key;
                upd_next   = 1'b0;
                state_next = S_UP_CHK;
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                popped_next = root;
                cnt_next    = cnt - CNT_W'(1);
                mem.raddr   = cnt;
                state_next  = (cnt == ROOT_IDX) ? S_DONE : S_POP_LAT;
              end
            end
            OP_UPDATE: begin
              if (slot == '0 || slot > cnt) begin
                status_next = ST_BADSLOT;
                state_next  = S_DONE;
              end else begin
                pos_next   = slot;
                cur_next   = key;
                upd_next   = 1'b1;
                state_next = S_UP_CHK;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_POP_LAT: begin
        cur_next   = rd_data;
        pos_next   = ROOT_IDX;
        state_next = S_DN_CHK;
      end
      S_UP_CHK: begin
        if (pos == ROOT_IDX) begin
          if (upd) begin
            upd_next   = 1'b0;
            state_next = S_DN_CHK;
          end else begin
            mem.we     = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          mem.raddr  = pos >> 1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (beats(order_mode, cur, rd_data)) begin
          mem.we     = 1'b1;
          mem.wdata  = rd_data;
          pos_next   = pos >> 1;
          upd_next   = 1'b0;
          state_next = S_UP_CHK;
        end else if (upd) begin
          // update that does not beat its parent: sift down instead
          upd_next   = 1'b0;
          state_next = S_DN_CHK;
        end else begin
          mem.we     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_CHK: begin
        if (child > cnt_x) begin
          mem.we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem.raddr  = child[CNT_W-1:0];
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        if (child_r <= cnt_x) begin
          lkey_next  = rd_data;
          mem.raddr  = child_r[CNT_W-1:0];
          state_next = S_DN_R;
        end else if (beats(order_mode, rd_data, cur)) begin
          mem.we     = 1'b1;
          mem.wdata  = rd_data;
          pos_next   = child[CNT_W-1:0];
          state_next = S_DN_CHK;
        end else begin
          mem.we     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_R: begin
        if (beats(order_mode, best_key, cur)) begin
          mem.we     = 1'b1;
          mem.wdata  = best_key;
          pos_next   = best_idx;
          state_next = S_DN_CHK;
        end else begin
          mem.we     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      upd   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      upd   <= upd_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    cur    <= cur_next;
    lkey   <= lkey_next;
    popped <= popped_next;
    status <= status_next;
    // keep a copy of the root slot alongside the memory
    if (mem.we && mem.waddr == ROOT_IDX) begin
      root <= mem.wdata;
    end
  end

  assign res.done   = (state == S_DONE);
  assign res.busy   = (state != S_IDLE);
  assign res.popped = popped;
  assign res.top    = (cnt != '0) ? root : '0;
  assign res.count  = cnt;
  assign res.status = status;

endmodule

>>> hw/rtl/binary_heap_priority_queue_core.sv
// Channel   Handshake               Fields
// input     start & !busy           operation, key, slot
// result    done (one cycle)        popped_key, top_key, entry_count, status
// config    cfg_we                  cfg_data (order_mode)
//
// One transaction at a time: busy drops the cycle after done. Each sift level up
// reads the parent; each level down reads the left, then the right child if there
// is one, and at most 9 levels are moved.
// Synchronous reset empties the heap and selects min order; no clearing pass.
// The result is shown when done is high; it is held until the next transaction is accepted.
module binary_heap_priority_queue_core
  import bhpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  operation,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] slot,
  input  logic             cfg_we,
  input  logic             cfg_data,
  output logic             done,
  output logic [KEY_W-1:0] popped_key,
  output logic [KEY_W-1:0] top_key,
  output logic [CNT_W-1:0] entry_count,
  output logic [ST_W-1:0]  status
);

  logic             order_mode;
  mem_req_t         mem;
  res_t             res;
  logic [KEY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      order_mode <= cfg_data;
    end
  end

  bhpq_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .order_mode (order_mode),
    .start      (start),
    .operation  (operation),
    .key        (key),
    .slot       (slot),
    .rd_data    (rd_data),
    .mem        (mem),
    .res        (res)
  );

  bhpq_ram #(
    .AW (CNT_W),
    .DW (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

  assign busy        = res.busy;
  assign done        = res.done;
  assign popped_key  = res.popped;
  assign top_key     = res.top;
  assign entry_count = res.count;
  assign status      = res.status;

endmodule

>>> hw/rtl/bhpq_chk.sv
module bhpq_chk
  import bhpq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [KEY_W-1:0] popped_key,
  input logic [CNT_W-1:0] entry_count,
  input logic [ST_W-1:0]  status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> entry_count == CAP_CNT)
    else $error("full reported below capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> entry_count == '0 && popped_key == '0)
    else $error("empty pop reported keys");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(done, 1) == 1'b0 && status == ST_OK && popped_key != '0
    |-> entry_count != CAP_CNT)
    else $error("successful pop left the heap full");

endmodule

bind binary_heap_priority_queue_core bhpq_chk u_bhpq_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .popped_key  (popped_key),
  .entry_count (entry_count),
  .status      (status)
);
